FILE: design/fpbs_pkg.sv
// Package holding the shared types, codes and bus-cycle microcode of the flash sequencer.
package fpbs_pkg;

  localparam int BLOCK_BYTES = 256;
  localparam int STEP_W      = $clog2(BLOCK_BYTES + 1);

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_SEND  = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    LAT_DATA = 2'd0,
    LAT_LOW  = 2'd1,
    LAT_HIGH = 2'd2
  } latch_e;

  typedef enum logic [2:0] {
    VS_CONST = 3'd0,
    VS_DATA  = 3'd1,
    VS_BANK  = 3'd2,
    VS_AH    = 3'd3,
    VS_AL    = 3'd4,
    VS_STEP  = 3'd5
  } vsel_e;

  typedef enum logic {
    SRC_HOST = 1'b0,
    SRC_BUS  = 1'b1
  } source_e;

  typedef enum logic {
    REG_MAKER_ID  = 1'b0,
    REG_DEVICE_ID = 1'b1
  } cfg_reg_e;

  // Host command codes
  localparam logic [7:0] CMD_SRAM_ON     = 8'd0;
  localparam logic [7:0] CMD_SRAM_OFF    = 8'd1;
  localparam logic [7:0] CMD_RD_SINGLE   = 8'd2;
  localparam logic [7:0] CMD_WR_SINGLE   = 8'd3;
  localparam logic [7:0] CMD_READ_BLK    = 8'd4;
  localparam logic [7:0] CMD_WRITE_BLK   = 8'd5;
  localparam logic [7:0] CMD_PROG_SINGLE = 8'd6;
  localparam logic [7:0] CMD_FLASH_BLK   = 8'd7;
  localparam logic [7:0] CMD_ADDR_BOTH   = 8'd8;
  localparam logic [7:0] CMD_ADDR_LOW    = 8'd9;
  localparam logic [7:0] CMD_ADDR_HIGH   = 8'd10;
  localparam logic [7:0] CMD_BANK        = 8'd11;
  localparam logic [7:0] CMD_ID_CHECK    = 8'd12;
  localparam logic [7:0] CMD_ERASE       = 8'd13;
  localparam logic [7:0] CMD_LOCK_ON     = 8'd14;
  localparam logic [7:0] CMD_LOCK_OFF    = 8'd15;
  localparam logic [7:0] CMD_LOOPBACK    = 8'd16;
  localparam logic [7:0] CMD_WHO_AM_I    = 8'd17;

  localparam logic [7:0] REPLY_DONE = 8'hD0;
  localparam logic [7:0] REPLY_BAD  = 8'hFF;
  localparam logic [7:0] REPLY_FAIL = 8'hFE;

  // Microcode routine start addresses
  localparam logic [7:0] U_SRAM_ON    = 8'd0;
  localparam logic [7:0] U_SRAM_OFF   = 8'd2;
  localparam logic [7:0] U_DONE       = 8'd4;
  localparam logic [7:0] U_READ       = 8'd5;
  localparam logic [7:0] U_RBLK_START = 8'd6;
  localparam logic [7:0] U_LOW0       = 8'd8;
  localparam logic [7:0] U_ECHO       = 8'd9;
  localparam logic [7:0] U_IDENT      = 8'd11;
  localparam logic [7:0] U_BAD        = 8'd15;
  localparam logic [7:0] U_WR_DONE    = 8'd16;
  localparam logic [7:0] U_WBLK_NEXT  = 8'd18;
  localparam logic [7:0] U_WBLK_END   = 8'd20;
  localparam logic [7:0] U_LOW_B      = 8'd23;
  localparam logic [7:0] U_HIGH_B     = 8'd24;
  localparam logic [7:0] U_LOW_B_DONE = 8'd26;
  localparam logic [7:0] U_BANK       = 8'd28;
  localparam logic [7:0] U_SEND_DONE  = 8'd32;
  localparam logic [7:0] U_RBLK_NEXT  = 8'd34;
  localparam logic [7:0] U_RBLK_END   = 8'd37;
  localparam logic [7:0] U_BLK_END    = 8'd40;
  localparam logic [7:0] U_ID_FAIL    = 8'd42;
  localparam logic [7:0] U_ID_NEXT    = 8'd44;
  localparam logic [7:0] U_ID_OK      = 8'd46;
  localparam logic [7:0] U_PROG       = 8'd48;
  localparam logic [7:0] U_IDCHK      = 8'd73;
  localparam logic [7:0] U_ERASE      = 8'd97;
  localparam logic [7:0] U_ERASE2     = 8'd115;
  localparam logic [7:0] U_LAST       = 8'd133;
  localparam logic [7:0] UNLOCK_LEN   = 8'd18;

  typedef struct packed {
    logic       source;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [1:0] action;
    logic [1:0] latch;
    logic [7:0] value;
    logic       last;
    logic       busy_led;
    logic       lock_led;
    logic       sram_select;
  } out_item_t;

  typedef struct packed {
    action_e    action;
    latch_e     latch;
    vsel_e      vsel;
    logic [7:0] cval;
    logic       fin;
  } ucode_t;

  typedef struct packed {
    logic   sram_set;
    logic   sram_clr;
    logic   lock_set;
    logic   lock_clr;
    logic   step_clr;
    logic   step_inc;
    logic   al_clr;
    logic   al_data;
    logic   al_step;
    logic   ah_data;
    logic   ah_inc;
    logic   bank_data;
    logic   pend_load;
    logic   item_load;
    logic   load;
    ucode_t entry;
  } dp_cmd_t;

  typedef struct packed {
    logic step_end;
    logic poll_match;
    logic maker_match;
    logic device_match;
    logic out_free;
  } dp_status_t;

  function automatic ucode_t mk(input action_e a, input latch_e l, input vsel_e v,
                                input logic [7:0] c, input logic f);
    ucode_t u;
    u.action = a;
    u.latch  = l;
    u.vsel   = v;
    u.cval   = c;
    u.fin    = f;
    return u;
  endfunction

  // One step of the three-write JEDEC unlock sequence, each write preceded by a bank select.
  function automatic ucode_t unlock_op(input logic [4:0] idx, input logic [7:0] cmd,
                                       input logic fin);
    ucode_t u;
    u = mk(ACT_WRITE, LAT_DATA, VS_CONST, 8'h00, 1'b0);
    case (idx)
      5'd0, 5'd6, 5'd12: u = mk(ACT_WRITE, LAT_HIGH, VS_CONST, 8'h20, 1'b0);
      5'd1, 5'd7, 5'd13: u = mk(ACT_WRITE, LAT_LOW, VS_CONST, 8'h00, 1'b0);
      5'd2, 5'd14:       u = mk(ACT_WRITE, LAT_DATA, VS_CONST, 8'h01, 1'b0);
      5'd8:              u = mk(ACT_WRITE, LAT_DATA, VS_CONST, 8'h00, 1'b0);
      5'd3, 5'd15:       u = mk(ACT_WRITE, LAT_HIGH, VS_CONST, 8'h55, 1'b0);
      5'd4, 5'd16:       u = mk(ACT_WRITE, LAT_LOW, VS_CONST, 8'h55, 1'b0);
      5'd5:              u = mk(ACT_WRITE, LAT_DATA, VS_CONST, 8'hAA, 1'b0);
      5'd9:              u = mk(ACT_WRITE, LAT_HIGH, VS_CONST, 8'h6A, 1'b0);
      5'd10:             u = mk(ACT_WRITE, LAT_LOW, VS_CONST, 8'hAA, 1'b0);
      5'd11:             u = mk(ACT_WRITE, LAT_DATA, VS_CONST, 8'h55, 1'b0);
      5'd17:             u = mk(ACT_WRITE, LAT_DATA, VS_CONST, cmd, fin);
      default:           u = mk(ACT_WRITE, LAT_DATA, VS_CONST, 8'h00, 1'b0);
    endcase
    return u;
  endfunction

  function automatic ucode_t ucode(input logic [7:0] addr);
    ucode_t u;
    u = mk(ACT_SEND, LAT_DATA, VS_CONST, REPLY_DONE, 1'b1);
    if (addr >= U_PROG && addr < U_PROG + UNLOCK_LEN) begin
      u = unlock_op(5'(addr - U_PROG), 8'hA0, 1'b0);
    end else if (addr >= U_IDCHK && addr < U_IDCHK + UNLOCK_LEN) begin
      u = unlock_op(5'(addr - U_IDCHK), 8'h90, 1'b0);
    end else if (addr >= U_ERASE && addr < U_ERASE + UNLOCK_LEN) begin
      u = unlock_op(5'(addr - U_ERASE), 8'h80, 1'b0);
    end else if (addr >= U_ERASE2 && addr < U_ERASE2 + UNLOCK_LEN) begin
      u = unlock_op(5'(addr - U_ERASE2), 8'h10, 1'b0);
    end else begin
      case (addr)
        8'd0:   u = mk(ACT_WRITE, LAT_HIGH, VS_CONST, 8'hFF, 1'b0);
        8'd2:   u = mk(ACT_WRITE, LAT_HIGH, VS_CONST, 8'h00, 1'b0);
        8'd5:   u = mk(ACT_READ, LAT_DATA, VS_CONST, 8'h00, 1'b1);
        8'd6:   u = mk(ACT_WRITE, LAT_LOW, VS_CONST, 8'h00, 1'b0);
        8'd7:   u = mk(ACT_READ, LAT_DATA, VS_CONST, 8'h00, 1'b1);
        8'd8:   u = mk(ACT_WRITE, LAT_LOW, VS_CONST, 8'h00, 1'b1);
        8'd9:   u = mk(ACT_SEND, LAT_DATA, VS_CONST, 8'h10, 1'b0);
        8'd11:  u = mk(ACT_SEND, LAT_DATA, VS_CONST, 8'h48, 1'b0);
        8'd12:  u = mk(ACT_SEND, LAT_DATA, VS_CONST, 8'h41, 1'b0);
        8'd13:  u = mk(ACT_SEND, LAT_DATA, VS_CONST, 8'h49, 1'b0);
        8'd15:  u = mk(ACT_SEND, LAT_DATA, VS_CONST, REPLY_BAD, 1'b1);
        8'd16:  u = mk(ACT_WRITE, LAT_DATA, VS_DATA, 8'h00, 1'b0);
        8'd18:  u = mk(ACT_WRITE, LAT_DATA, VS_DATA, 8'h00, 1'b0);
        8'd19:  u = mk(ACT_WRITE, LAT_LOW, VS_STEP, 8'h00, 1'b1);
        8'd20:  u = mk(ACT_WRITE, LAT_DATA, VS_DATA, 8'h00, 1'b0);
        8'd21:  u = mk(ACT_WRITE, LAT_HIGH, VS_AH, 8'h00, 1'b0);
        8'd23:  u = mk(ACT_WRITE, LAT_LOW, VS_DATA, 8'h00, 1'b1);
        8'd24:  u = mk(ACT_WRITE, LAT_HIGH, VS_DATA, 8'h00, 1'b0);
        8'd26:  u = mk(ACT_WRITE, LAT_LOW, VS_DATA, 8'h00, 1'b0);
        8'd28:  u = mk(ACT_WRITE, LAT_HIGH, VS_CONST, 8'h20, 1'b0);
        8'd29:  u = mk(ACT_WRITE, LAT_LOW, VS_CONST, 8'h00, 1'b0);
        8'd30:  u = mk(ACT_WRITE, LAT_DATA, VS_DATA, 8'h00, 1'b0);
        8'd32:  u = mk(ACT_SEND, LAT_DATA, VS_DATA, 8'h00, 1'b0);
        8'd34:  u = mk(ACT_SEND, LAT_DATA, VS_DATA, 8'h00, 1'b0);
        8'd35:  u = mk(ACT_WRITE, LAT_LOW, VS_STEP, 8'h00, 1'b0);
        8'd36:  u = mk(ACT_READ, LAT_DATA, VS_CONST, 8'h00, 1'b1);
        8'd37:  u = mk(ACT_SEND, LAT_DATA, VS_DATA, 8'h00, 1'b0);
        8'd38:  u = mk(ACT_WRITE, LAT_HIGH, VS_AH, 8'h00, 1'b0);
        8'd40:  u = mk(ACT_WRITE, LAT_HIGH, VS_AH, 8'h00, 1'b0);
        8'd42:  u = mk(ACT_WRITE, LAT_DATA, VS_CONST, 8'hF0, 1'b0);
        8'd43:  u = mk(ACT_SEND, LAT_DATA, VS_CONST, REPLY_FAIL, 1'b1);
        8'd44:  u = mk(ACT_WRITE, LAT_LOW, VS_CONST, 8'h01, 1'b0);
        8'd45:  u = mk(ACT_READ, LAT_DATA, VS_CONST, 8'h00, 1'b1);
        8'd46:  u = mk(ACT_WRITE, LAT_DATA, VS_CONST, 8'hF0, 1'b0);
        8'd66:  u = mk(ACT_WRITE, LAT_HIGH, VS_CONST, 8'h20, 1'b0);
        8'd67:  u = mk(ACT_WRITE, LAT_LOW, VS_CONST, 8'h00, 1'b0);
        8'd68:  u = mk(ACT_WRITE, LAT_DATA, VS_BANK, 8'h00, 1'b0);
        8'd69:  u = mk(ACT_WRITE, LAT_HIGH, VS_AH, 8'h40, 1'b0);
        8'd70:  u = mk(ACT_WRITE, LAT_LOW, VS_AL, 8'h00, 1'b0);
        8'd71:  u = mk(ACT_WRITE, LAT_DATA, VS_DATA, 8'h00, 1'b0);
        8'd72:  u = mk(ACT_READ, LAT_DATA, VS_CONST, 8'h00, 1'b1);
        8'd91:  u = mk(ACT_WRITE, LAT_HIGH, VS_CONST, 8'h20, 1'b0);
        8'd92:  u = mk(ACT_WRITE, LAT_LOW, VS_CONST, 8'h00, 1'b0);
        8'd93:  u = mk(ACT_WRITE, LAT_DATA, VS_CONST, 8'h00, 1'b0);
        8'd94:  u = mk(ACT_WRITE, LAT_HIGH, VS_CONST, 8'h00, 1'b0);
        8'd95:  u = mk(ACT_WRITE, LAT_LOW, VS_CONST, 8'h00, 1'b0);
        8'd96:  u = mk(ACT_READ, LAT_DATA, VS_CONST, 8'h00, 1'b1);
        8'd133: u = mk(ACT_READ, LAT_DATA, VS_CONST, 8'h00, 1'b1);
        default: u = mk(ACT_SEND, LAT_DATA, VS_CONST, REPLY_DONE, 1'b1);
      endcase
    end
    return u;
  endfunction

endpackage

FILE: design/fpbs_datapath.sv
// Datapath of the flash programmer sequencer: address, bank and flag registers and the output word register.
module fpbs_datapath import fpbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic [7:0] item_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  input  logic       out_stall_i,
  output logic       out_valid_o,
  output out_item_t  out_data_o
);

  logic [7:0]        maker_q, device_q;
  logic [7:0]        al_q, al_d, ah_q, ah_d, bank_q, bank_d;
  logic [7:0]        pend_q, pend_d, item_q, item_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              sram_q, sram_d, lock_q, lock_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic [7:0]        sel_val, bus_val;

  always_comb begin
    al_d = al_q;
    if (cmd_i.al_clr) begin
      al_d = 8'h00;
    end else if (cmd_i.al_data) begin
      al_d = item_data_i;
    end else if (cmd_i.al_step) begin
      al_d = 8'(step_q);
    end
    ah_d = ah_q;
    if (cmd_i.ah_data) begin
      ah_d = item_data_i;
    end else if (cmd_i.ah_inc) begin
      ah_d = ah_q + 8'd1;
    end
    bank_d = cmd_i.bank_data ? item_data_i : bank_q;
    pend_d = cmd_i.pend_load ? item_data_i : pend_q;
    item_d = cmd_i.item_load ? item_data_i : item_q;
    step_d = step_q;
    if (cmd_i.step_clr) begin
      step_d = '0;
    end else if (cmd_i.step_inc) begin
      step_d = step_q + STEP_W'(1);
    end
    sram_d = (sram_q | cmd_i.sram_set) & ~cmd_i.sram_clr;
    lock_d = (lock_q | cmd_i.lock_set) & ~cmd_i.lock_clr;
  end

  always_comb begin
    case (cmd_i.entry.vsel)
      VS_CONST: sel_val = 8'h00;
      VS_DATA:  sel_val = item_q;
      VS_BANK:  sel_val = bank_q;
      VS_AH:    sel_val = ah_q;
      VS_AL:    sel_val = al_q;
      VS_STEP:  sel_val = 8'(step_q);
      default:  sel_val = 8'h00;
    endcase
    bus_val = sel_val | cmd_i.entry.cval;
    // A15 is held high on every high-latch write while the cartridge RAM is selected.
    if (cmd_i.entry.action == ACT_WRITE && cmd_i.entry.latch == LAT_HIGH && sram_q) begin
      bus_val = bus_val | 8'h80;
    end
    out_d.action      = cmd_i.entry.action;
    out_d.latch       = cmd_i.entry.latch;
    out_d.value       = bus_val;
    out_d.last        = cmd_i.entry.fin;
    out_d.busy_led    = 1'b1;
    out_d.lock_led    = lock_q;
    out_d.sram_select = ~sram_q;
  end

  always_comb begin
    out_valid_d = out_valid_q & out_stall_i;
    if (cmd_i.load) begin
      out_valid_d = 1'b1;
    end
  end

  assign status_o.step_end     = (step_q == STEP_W'(BLOCK_BYTES - 1));
  assign status_o.poll_match   = (item_data_i[7] == pend_q[7]);
  assign status_o.maker_match  = (item_data_i == maker_q);
  assign status_o.device_match = (item_data_i == device_q);
  assign status_o.out_free     = ~out_valid_q | ~out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maker_q     <= 8'hBF;
      device_q    <= 8'hB7;
      al_q        <= 8'h00;
      ah_q        <= 8'h00;
      bank_q      <= 8'h00;
      pend_q      <= 8'h00;
      step_q      <= '0;
      sram_q      <= 1'b0;
      lock_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == REG_MAKER_ID) begin
        maker_q <= cfg_wdata_i;
      end
      if (cfg_we_i && cfg_index_i == REG_DEVICE_ID) begin
        device_q <= cfg_wdata_i;
      end
      al_q        <= al_d;
      ah_q        <= ah_d;
      bank_q      <= bank_d;
      pend_q      <= pend_d;
      step_q      <= step_d;
      sram_q      <= sram_d;
      lock_q      <= lock_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    if (cmd_i.load) begin
      out_q <= out_d;
    end
  end

  step_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= STEP_W'(BLOCK_BYTES)) else $error("step counter past block size");

endmodule

FILE: design/fpbs_controller.sv
// Controller of the flash programmer sequencer: command phase machine and microcode sequencer.
module fpbs_controller import fpbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  in_item_t   in_data_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [16:0] {
    PH_IDLE       = 17'h00001,
    PH_READ_ONE   = 17'h00002,
    PH_WRITE_ONE  = 17'h00004,
    PH_READ_BLK   = 17'h00008,
    PH_WRITE_BLK  = 17'h00010,
    PH_FLASH_ONE  = 17'h00020,
    PH_POLL_ONE   = 17'h00040,
    PH_FLASH_BLK  = 17'h00080,
    PH_POLL_BLK   = 17'h00100,
    PH_ADDR_BOTH  = 17'h00200,
    PH_ADDR_HIGH2 = 17'h00400,
    PH_ADDR_LOW   = 17'h00800,
    PH_ADDR_HIGH  = 17'h01000,
    PH_BANK       = 17'h02000,
    PH_ID_MAKER   = 17'h04000,
    PH_ID_DEVICE  = 17'h08000,
    PH_ERASE_POLL = 17'h10000
  } phase_e;

  typedef enum logic [1:0] {
    SQ_IDLE = 2'b01,
    SQ_RUN  = 2'b10
  } seq_e;

  phase_e     phase_q, phase_d;
  seq_e       seq_q, seq_d;
  logic [7:0] pc_q, pc_d;
  logic       accept, go;
  logic [7:0] start;
  logic [7:0] code;
  logic       host;

  assign accept     = in_valid_i & (seq_q == SQ_IDLE);
  assign in_stall_o = (seq_q == SQ_RUN);
  assign code       = in_data_i.data;
  assign host       = (in_data_i.source == SRC_HOST);

  always_comb begin
    cmd_o           = '0;
    cmd_o.entry     = ucode(pc_q);
    phase_d         = phase_q;
    go              = 1'b0;
    start           = U_DONE;
    if (accept) begin
      cmd_o.item_load = 1'b1;
      if (host) begin
        case (phase_q)
          PH_IDLE: begin
            go = 1'b1;
            case (code)
              CMD_SRAM_ON:   begin cmd_o.sram_set = 1'b1; start = U_SRAM_ON; end
              CMD_SRAM_OFF:  begin cmd_o.sram_clr = 1'b1; start = U_SRAM_OFF; end
              CMD_RD_SINGLE: begin start = U_READ; phase_d = PH_READ_ONE; end
              CMD_WR_SINGLE: begin go = 1'b0; phase_d = PH_WRITE_ONE; end
              CMD_READ_BLK: begin
                cmd_o.step_clr = 1'b1;
                start          = U_RBLK_START;
                phase_d        = PH_READ_BLK;
              end
              CMD_WRITE_BLK: begin
                cmd_o.step_clr = 1'b1;
                start          = U_LOW0;
                phase_d        = PH_WRITE_BLK;
              end
              CMD_PROG_SINGLE: begin go = 1'b0; phase_d = PH_FLASH_ONE; end
              CMD_FLASH_BLK: begin
                go             = 1'b0;
                cmd_o.step_clr = 1'b1;
                cmd_o.al_clr   = 1'b1;
                phase_d        = PH_FLASH_BLK;
              end
              CMD_ADDR_BOTH: begin go = 1'b0; phase_d = PH_ADDR_BOTH; end
              CMD_ADDR_LOW:  begin go = 1'b0; phase_d = PH_ADDR_LOW; end
              CMD_ADDR_HIGH: begin go = 1'b0; phase_d = PH_ADDR_HIGH; end
              CMD_BANK:      begin go = 1'b0; phase_d = PH_BANK; end
              CMD_ID_CHECK:  begin start = U_IDCHK; phase_d = PH_ID_MAKER; end
              CMD_ERASE:     begin start = U_ERASE; phase_d = PH_ERASE_POLL; end
              CMD_LOCK_ON:   begin cmd_o.lock_set = 1'b1; start = U_DONE; end
              CMD_LOCK_OFF:  begin cmd_o.lock_clr = 1'b1; start = U_DONE; end
              CMD_LOOPBACK:  start = U_ECHO;
              CMD_WHO_AM_I:  start = U_IDENT;
              default:       start = U_BAD;
            endcase
          end
          PH_WRITE_ONE: begin go = 1'b1; start = U_WR_DONE; phase_d = PH_IDLE; end
          PH_WRITE_BLK: begin
            go             = 1'b1;
            cmd_o.step_inc = 1'b1;
            if (status_i.step_end) begin
              cmd_o.ah_inc = 1'b1;
              start        = U_WBLK_END;
              phase_d      = PH_IDLE;
            end else begin
              start = U_WBLK_NEXT;
            end
          end
          PH_FLASH_ONE: begin
            go              = 1'b1;
            cmd_o.pend_load = 1'b1;
            start           = U_PROG;
            phase_d         = PH_POLL_ONE;
          end
          PH_FLASH_BLK: begin
            go              = 1'b1;
            cmd_o.al_step   = 1'b1;
            cmd_o.pend_load = 1'b1;
            start           = U_PROG;
            phase_d         = PH_POLL_BLK;
          end
          PH_ADDR_BOTH: begin
            go            = 1'b1;
            cmd_o.al_data = 1'b1;
            start         = U_LOW_B;
            phase_d       = PH_ADDR_HIGH2;
          end
          PH_ADDR_HIGH2, PH_ADDR_HIGH: begin
            go            = 1'b1;
            cmd_o.ah_data = 1'b1;
            start         = U_HIGH_B;
            phase_d       = PH_IDLE;
          end
          PH_ADDR_LOW: begin
            go            = 1'b1;
            cmd_o.al_data = 1'b1;
            start         = U_LOW_B_DONE;
            phase_d       = PH_IDLE;
          end
          PH_BANK: begin
            go              = 1'b1;
            cmd_o.bank_data = 1'b1;
            start           = U_BANK;
            phase_d         = PH_IDLE;
          end
          default: go = 1'b0;
        endcase
      end else begin
        case (phase_q)
          PH_READ_ONE: begin go = 1'b1; start = U_SEND_DONE; phase_d = PH_IDLE; end
          PH_READ_BLK: begin
            go             = 1'b1;
            cmd_o.step_inc = 1'b1;
            if (status_i.step_end) begin
              cmd_o.ah_inc = 1'b1;
              start        = U_RBLK_END;
              phase_d      = PH_IDLE;
            end else begin
              start = U_RBLK_NEXT;
            end
          end
          PH_POLL_ONE: begin
            go = 1'b1;
            if (status_i.poll_match) begin
              start   = U_DONE;
              phase_d = PH_IDLE;
            end else begin
              start = U_READ;
            end
          end
          PH_POLL_BLK: begin
            if (status_i.poll_match) begin
              cmd_o.step_inc = 1'b1;
              if (status_i.step_end) begin
                go           = 1'b1;
                cmd_o.ah_inc = 1'b1;
                cmd_o.al_clr = 1'b1;
                start        = U_BLK_END;
                phase_d      = PH_IDLE;
              end else begin
                phase_d = PH_FLASH_BLK;
              end
            end else begin
              go    = 1'b1;
              start = U_READ;
            end
          end
          PH_ID_MAKER: begin
            go = 1'b1;
            if (status_i.maker_match) begin
              start   = U_ID_NEXT;
              phase_d = PH_ID_DEVICE;
            end else begin
              start   = U_ID_FAIL;
              phase_d = PH_IDLE;
            end
          end
          PH_ID_DEVICE: begin
            go      = 1'b1;
            start   = status_i.device_match ? U_ID_OK : U_ID_FAIL;
            phase_d = PH_IDLE;
          end
          PH_ERASE_POLL: begin
            go = 1'b1;
            if (code[7]) begin
              start   = U_DONE;
              phase_d = PH_IDLE;
            end else begin
              start = U_READ;
            end
          end
          default: go = 1'b0;
        endcase
      end
    end
    cmd_o.load = (seq_q == SQ_RUN) & status_i.out_free;
  end

  always_comb begin
    seq_d = seq_q;
    pc_d  = pc_q;
    case (seq_q)
      SQ_IDLE: begin
        if (go) begin
          seq_d = SQ_RUN;
          pc_d  = start;
        end
      end
      SQ_RUN: begin
        if (cmd_o.load) begin
          if (cmd_o.entry.fin) begin
            seq_d = SQ_IDLE;
          end else begin
            pc_d = pc_q + 8'd1;
          end
        end
      end
      default: seq_d = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      seq_q   <= SQ_IDLE;
      pc_q    <= 8'd0;
    end else begin
      phase_q <= phase_d;
      seq_q   <= seq_d;
      pc_q    <= pc_d;
    end
  end

  fin_ends_run_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_RUN && cmd_o.load && cmd_o.entry.fin) |=> (seq_q == SQ_IDLE))
    else $error("sequencer kept running after the final word");

  pc_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_RUN) |-> (pc_q <= U_LAST))
    else $error("microcode address out of range");

  no_load_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_IDLE) |-> !cmd_o.load)
    else $error("word loaded while sequencer idle");

endmodule

FILE: design/flash_programmer_bus_sequencer.sv
// Top level of the flash programmer bus sequencer: controller and datapath joined.
//
// The block turns host command bytes and bus read data into a stream of output
// words, each one a bus write (data, low or high address latch), a bus read
// request or a byte for the host. An input word is taken only while the block
// holds no unfinished work; it is decoded in the cycle it is taken and the words
// it causes are issued by a microcode sequencer into the output register at one
// word per clock while the output side does not stall, so an item occupies the
// block until its last result word is loaded (chip erase issues 37 words). An
// item that causes no words frees the block in the cycle after it is taken.
// Words leave through a registered output stage, so the last word of an item
// may still wait there while the next input word is accepted. The last field
// marks the final word of an item; busy_led is high on every word, and
// lock_led and sram_select give the LED and RAM select levels when the word
// was formed. The two ID registers may be written only while the block is
// idle.
module flash_programmer_bus_sequencer import fpbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // The controller owns the command phase and the microcode address.
  fpbs_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds addresses, bank, flags and the output register.
  fpbs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_data_i (in_data_i.data),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: verif/fpbs_checker.sv
// Checker for the flash programmer bus sequencer: predicts output words and compares them.
module fpbs_checker import fpbs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  in_item_t   in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  out_item_t  out_data_i,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  output int         mismatch_count_o,
  output int         words_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [4:0] {
    PH_IDLE, PH_READ_ONE, PH_WRITE_ONE, PH_READ_BLK, PH_WRITE_BLK, PH_FLASH_ONE,
    PH_POLL_ONE, PH_FLASH_BLK, PH_POLL_BLK, PH_ADDR_BOTH, PH_ADDR_HIGH2, PH_ADDR_LOW,
    PH_ADDR_HIGH, PH_BANK, PH_ID_MAKER, PH_ID_DEVICE, PH_ERASE_POLL
  } seq_phase_e;

  seq_phase_e ph;
  logic [8:0] steps;
  logic [7:0] addr_lo, addr_hi, bank_no, pend, maker_id, device_id;
  logic       ram_on, lock_on;
  out_item_t  owed_words[$];
  int         made;

  assign words_owed_o = owed_words.size();

  task automatic put(action_e a, latch_e l, logic [7:0] v);
    out_item_t r;
    r.action      = a;
    r.latch       = l;
    r.value       = v;
    r.last        = 1'b0;
    r.busy_led    = 1'b1;
    r.lock_led    = lock_on;
    r.sram_select = ~ram_on;
    if (made < 37) begin
      owed_words.push_back(r);
      made++;
    end
  endtask

  task automatic wr_data(logic [7:0] v); put(ACT_WRITE, LAT_DATA, v); endtask
  task automatic wr_low(logic [7:0] v);  put(ACT_WRITE, LAT_LOW, v);  endtask
  task automatic wr_high(logic [7:0] v); put(ACT_WRITE, LAT_HIGH, ram_on ? (v | 8'h80) : v); endtask
  task automatic rd_req();               put(ACT_READ, LAT_DATA, 8'h00); endtask
  task automatic to_host(logic [7:0] v); put(ACT_SEND, LAT_DATA, v); endtask

  task automatic finish_cmd();
    to_host(REPLY_DONE);
    ph = PH_IDLE;
  endtask

  task automatic bank_select(logic [7:0] b);
    wr_high(8'h20);
    wr_low(8'h00);
    wr_data(b);
  endtask

  task automatic unlock_seq(logic [7:0] c);
    bank_select(8'h01); wr_high(8'h55); wr_low(8'h55); wr_data(8'hAA);
    bank_select(8'h00); wr_high(8'h6A); wr_low(8'hAA); wr_data(8'h55);
    bank_select(8'h01); wr_high(8'h55); wr_low(8'h55); wr_data(c);
  endtask

  task automatic program_byte(logic [7:0] b);
    pend = b;
    unlock_seq(8'hA0);
    bank_select(bank_no);
    wr_high(8'h40 | addr_hi);
    wr_low(addr_lo);
    wr_data(b);
    rd_req();
  endtask

  task automatic host_word(logic [7:0] b);
    case (ph)
      PH_IDLE: begin
        case (b)
          CMD_SRAM_ON: begin ram_on = 1'b1; wr_high(8'hFF); finish_cmd(); end
          CMD_SRAM_OFF: begin ram_on = 1'b0; wr_high(8'h00); finish_cmd(); end
          CMD_RD_SINGLE: begin rd_req(); ph = PH_READ_ONE; end
          CMD_WR_SINGLE: ph = PH_WRITE_ONE;
          CMD_READ_BLK: begin steps = '0; wr_low(8'h00); rd_req(); ph = PH_READ_BLK; end
          CMD_WRITE_BLK: begin steps = '0; wr_low(8'h00); ph = PH_WRITE_BLK; end
          CMD_PROG_SINGLE: ph = PH_FLASH_ONE;
          CMD_FLASH_BLK: begin steps = '0; addr_lo = '0; ph = PH_FLASH_BLK; end
          CMD_ADDR_BOTH: ph = PH_ADDR_BOTH;
          CMD_ADDR_LOW: ph = PH_ADDR_LOW;
          CMD_ADDR_HIGH: ph = PH_ADDR_HIGH;
          CMD_BANK: ph = PH_BANK;
          CMD_ID_CHECK: begin
            unlock_seq(8'h90);
            bank_select(8'h00);
            wr_high(8'h00);
            wr_low(8'h00);
            rd_req();
            ph = PH_ID_MAKER;
          end
          CMD_ERASE: begin
            unlock_seq(8'h80);
            unlock_seq(8'h10);
            rd_req();
            ph = PH_ERASE_POLL;
          end
          CMD_LOCK_ON: begin lock_on = 1'b1; finish_cmd(); end
          CMD_LOCK_OFF: begin lock_on = 1'b0; finish_cmd(); end
          CMD_LOOPBACK: begin to_host(8'h10); finish_cmd(); end
          CMD_WHO_AM_I: begin
            to_host(8'h48); to_host(8'h41); to_host(8'h49); finish_cmd();
          end
          default: begin to_host(REPLY_BAD); ph = PH_IDLE; end
        endcase
      end
      PH_WRITE_ONE: begin wr_data(b); finish_cmd(); end
      PH_WRITE_BLK: begin
        wr_data(b);
        steps++;
        if (steps < BLOCK_BYTES) begin
          wr_low(steps[7:0]);
        end else begin
          addr_hi++;
          wr_high(addr_hi);
          finish_cmd();
        end
      end
      PH_FLASH_ONE: begin program_byte(b); ph = PH_POLL_ONE; end
      PH_FLASH_BLK: begin addr_lo = steps[7:0]; program_byte(b); ph = PH_POLL_BLK; end
      PH_ADDR_BOTH: begin addr_lo = b; wr_low(b); ph = PH_ADDR_HIGH2; end
      PH_ADDR_HIGH2, PH_ADDR_HIGH: begin addr_hi = b; wr_high(b); finish_cmd(); end
      PH_ADDR_LOW: begin addr_lo = b; wr_low(b); finish_cmd(); end
      PH_BANK: begin bank_no = b; bank_select(b); finish_cmd(); end
      default: ;
    endcase
  endtask

  task automatic bus_word(logic [7:0] d);
    case (ph)
      PH_READ_ONE: begin to_host(d); finish_cmd(); end
      PH_READ_BLK: begin
        to_host(d);
        steps++;
        if (steps < BLOCK_BYTES) begin
          wr_low(steps[7:0]);
          rd_req();
        end else begin
          addr_hi++;
          wr_high(addr_hi);
          finish_cmd();
        end
      end
      PH_POLL_ONE: if (d[7] == pend[7]) finish_cmd(); else rd_req();
      PH_POLL_BLK: begin
        if (d[7] == pend[7]) begin
          steps++;
          if (steps < BLOCK_BYTES) begin
            ph = PH_FLASH_BLK;
          end else begin
            addr_hi++;
            wr_high(addr_hi);
            addr_lo = '0;
            finish_cmd();
          end
        end else begin
          rd_req();
        end
      end
      PH_ID_MAKER: begin
        if (d != maker_id) begin
          wr_data(8'hF0); to_host(REPLY_FAIL); ph = PH_IDLE;
        end else begin
          wr_low(8'h01); rd_req(); ph = PH_ID_DEVICE;
        end
      end
      PH_ID_DEVICE: begin
        wr_data(8'hF0);
        if (d != device_id) begin
          to_host(REPLY_FAIL); ph = PH_IDLE;
        end else begin
          finish_cmd();
        end
      end
      PH_ERASE_POLL: if (d[7]) finish_cmd(); else rd_req();
      default: ;
    endcase
  endtask

  task automatic report(string field, logic [15:0] got, logic [15:0] want);
    $display("%0t: output word %s is %0h, predicted %0h", $realtime, field, got, want);
    mismatch_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t w;
    int queued_prior;
    if (!rst_ni) begin
      ph = PH_IDLE; steps = '0; addr_lo = '0; addr_hi = '0; bank_no = '0; pend = '0;
      ram_on = 1'b0; lock_on = 1'b0; maker_id = 8'hBF; device_id = 8'hB7;
      owed_words.delete();
      mismatch_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_words.size() == 0) begin
          report("with none predicted", out_data_i, 16'h0000);
        end else begin
          w = owed_words.pop_front();
          if (out_data_i.action != w.action)
            report("action", 16'(out_data_i.action), 16'(w.action));
          if (out_data_i.latch != w.latch)
            report("latch", 16'(out_data_i.latch), 16'(w.latch));
          if (out_data_i.value != w.value)
            report("value", 16'(out_data_i.value), 16'(w.value));
          if (out_data_i.last != w.last)
            report("last", 16'(out_data_i.last), 16'(w.last));
          if (out_data_i.busy_led != w.busy_led)
            report("busy_led", 16'(out_data_i.busy_led), 16'(w.busy_led));
          if (out_data_i.lock_led != w.lock_led)
            report("lock_led", 16'(out_data_i.lock_led), 16'(w.lock_led));
          if (out_data_i.sram_select != w.sram_select)
            report("sram_select", 16'(out_data_i.sram_select), 16'(w.sram_select));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        made = 0;
        queued_prior = owed_words.size();
        if (in_data_i.source == SRC_HOST) host_word(in_data_i.data);
        else bus_word(in_data_i.data);
        if (owed_words.size() > queued_prior) owed_words[owed_words.size() - 1].last = 1'b1;
      end
      if (cfg_we_i) begin
        if (cfg_index_i == REG_MAKER_ID) maker_id = cfg_wdata_i;
        else device_id = cfg_wdata_i;
      end
    end
  end

endmodule

FILE: verif/tb.sv
// Testbench top for the flash programmer bus sequencer: stimulus, stalls and verdict.
module tb;
  import fpbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_word;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_word;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_wdata;
  int         mismatches;
  int         words_owed;

  // The stimulus keeps its own copy of the ID registers so that it can aim
  // ID checks at both the matching and the failing path.
  logic [7:0] maker_id_now;
  logic [7:0] device_id_now;
  idle_mode_e idle_mode;
  logic       hold_req;
  int         hold_left;
  int         items_sent;
  int         quiet_cycles;

  flash_programmer_bus_sequencer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  fpbs_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_word),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_word),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatches),
    .words_owed_o     (words_owed)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls by phase, plus one long hold-off counted here when
  // the stimulus asks for it, so that the block backs up and stalls its input.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req) begin
      out_stall <= 1'b1;
      hold_left <= 400;
    end else begin
      case (idle_mode)
        IDLE_RECV: out_stall <= ($urandom_range(99) < 71);
        IDLE_BOTH: out_stall <= ($urandom_range(99) < 11);
        default:   out_stall <= 1'b0;
      endcase
    end
  end

  // Watchdog: a long run of cycles in which neither channel moves a word
  // means the block has hung.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles > 5000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Offers one word and waits until the block takes it. The valid is only
  // lowered when a gap follows, so it never drops and rises in one step.
  task automatic send_word(source_e src, logic [7:0] d);
    int gap;
    int idle_pct;
    gap = 0;
    idle_pct = (idle_mode == IDLE_SEND) ? 71 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    in_word.source <= src;
    in_word.data   <= d;
    do @(posedge clk_i); while (in_stall);
    items_sent++;
  endtask

  // Pauses the sender until every predicted word has left, then allows for
  // an item that causes no words still being at work.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (words_owed != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [7:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    if (idx == REG_MAKER_ID) maker_id_now = v;
    else device_id_now = v;
  endtask

  // Polling answers: a few with the completion bit wrong, then one with it right.
  task automatic poll_answers(logic want7, int misses);
    repeat (misses) send_word(SRC_BUS, {~want7, 7'($urandom)});
    send_word(SRC_BUS, {want7, 7'($urandom)});
  endtask

  // Drives one whole host command with its argument words and bus answers.
  task automatic run_command(logic [7:0] cmd);
    logic [7:0] b;
    send_word(SRC_HOST, cmd);
    case (cmd)
      CMD_RD_SINGLE: send_word(SRC_BUS, 8'($urandom));
      CMD_WR_SINGLE, CMD_ADDR_LOW, CMD_ADDR_HIGH, CMD_BANK:
        send_word(SRC_HOST, 8'($urandom));
      CMD_ADDR_BOTH: begin
        send_word(SRC_HOST, 8'($urandom));
        send_word(SRC_HOST, 8'($urandom));
      end
      CMD_READ_BLK: repeat (BLOCK_BYTES) send_word(SRC_BUS, 8'($urandom));
      CMD_WRITE_BLK: repeat (BLOCK_BYTES) send_word(SRC_HOST, 8'($urandom));
      CMD_PROG_SINGLE: begin
        b = 8'($urandom);
        send_word(SRC_HOST, b);
        // A host word during polling is ignored.
        if ($urandom_range(3) == 0) send_word(SRC_HOST, 8'($urandom));
        poll_answers(b[7], $urandom_range(3));
      end
      CMD_FLASH_BLK: begin
        repeat (BLOCK_BYTES) begin
          b = 8'($urandom);
          send_word(SRC_HOST, b);
          poll_answers(b[7], ($urandom_range(7) == 0) ? 1 : 0);
        end
      end
      CMD_ID_CHECK: begin
        if ($urandom_range(3) == 0) begin
          send_word(SRC_BUS, maker_id_now ^ (8'h01 << $urandom_range(7)));
        end else begin
          send_word(SRC_BUS, maker_id_now);
          if ($urandom_range(2) == 0) send_word(SRC_BUS, device_id_now ^ 8'h80);
          else send_word(SRC_BUS, device_id_now);
        end
      end
      CMD_ERASE: poll_answers(1'b1, $urandom_range(4));
      default: ;
    endcase
  endtask

  initial begin
    logic [7:0] c;
    int roll;
    rst_ni        = 1'b0;
    in_valid      = 1'b0;
    in_word       = '0;
    cfg_we        = 1'b0;
    cfg_index     = 1'b0;
    cfg_wdata     = '0;
    hold_req      = 1'b0;
    idle_mode     = IDLE_NONE;
    maker_id_now  = 8'hBF;
    device_id_now = 8'hB7;
    items_sent    = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every command but the three block commands once, the unknown codes
    // at both ends, and a bus word while idle, which the block ignores.
    send_word(SRC_BUS, 8'hFF);
    for (int k = CMD_SRAM_ON; k <= CMD_WHO_AM_I; k++) begin
      if (k != CMD_READ_BLK && k != CMD_WRITE_BLK && k != CMD_FLASH_BLK) run_command(8'(k));
    end
    run_command(8'd18);
    run_command(8'hFF);
    drain();
    write_reg(REG_MAKER_ID, 8'h00);
    write_reg(REG_DEVICE_ID, 8'hFF);
    run_command(CMD_ID_CHECK);
    run_command(CMD_SRAM_ON);
    run_command(CMD_ADDR_HIGH);

    // Long hold-off at the receiver while the sender keeps offering words.
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    repeat (12) run_command(CMD_WHO_AM_I);

    // Random commands, changing the idling phase and the ID registers often.
    for (int round = 0; round < 5; round++) begin
      drain();
      idle_mode = idle_mode_e'(round % 4);
      write_reg(REG_MAKER_ID, (round == 3) ? 8'hBF : 8'($urandom));
      write_reg(REG_DEVICE_ID, (round == 3) ? 8'hB7 : 8'($urandom));
      repeat (8) begin
        roll = $urandom_range(99);
        if (roll < 8) c = 8'($urandom_range(18, 255));
        else c = 8'($urandom_range(CMD_SRAM_ON, CMD_WHO_AM_I));
        if (c == CMD_READ_BLK || c == CMD_WRITE_BLK || c == CMD_FLASH_BLK) c = CMD_ID_CHECK;
        if (roll >= 96) send_word(SRC_BUS, 8'($urandom));
        run_command(c);
      end
    end

    // A flash block is started last and only its first bytes are sent, as a
    // whole block needs far more words than the rest of the run together.
    drain();
    idle_mode = IDLE_BOTH;
    send_word(SRC_HOST, CMD_FLASH_BLK);
    repeat (8) begin
      c = 8'($urandom);
      send_word(SRC_HOST, c);
      poll_answers(c[7], ($urandom_range(3) == 0) ? 1 : 0);
    end

    drain();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && words_owed == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
